/* design/ohs_pkg.sv */
// Shared constants and types of the open-addressing hash set.
package ohs_pkg;

  localparam int SLOTS       = 1024;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int PROBE_LIMIT = SLOTS + 13;
  localparam int PRB_W       = $clog2(PROBE_LIMIT + 1);
  localparam int CNT_W       = 11;
  localparam int KEY_W       = 64;
  localparam int PERT_SHIFT  = 5;
  localparam int WORD_W      = KEY_W + 1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(665);

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_word_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_word_t       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic             empty;
    logic             match;
    logic [IDX_W-1:0] nxt_idx;
    logic [KEY_W-1:0] nxt_perturb;
  } probe_res_t;

endpackage

/* design/ohs_slot_ram.sv */
// Slot memory: one valid bit and one key per slot, registered read.
module ohs_slot_ram (
  input  logic               clk,
  input  ohs_pkg::ram_req_t  req,
  output ohs_pkg::slot_word_t rd_data
);

  ohs_pkg::slot_word_t mem [ohs_pkg::SLOTS];
  ohs_pkg::slot_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ohs_probe_unit.sv */
// Probe step: test a slot against the key and form the next probe index.
module ohs_probe_unit (
  input  ohs_pkg::slot_word_t               slot,
  input  logic [ohs_pkg::KEY_W-1:0]         key,
  input  logic [ohs_pkg::IDX_W-1:0]         idx,
  input  logic [ohs_pkg::KEY_W-1:0]         perturb,
  output ohs_pkg::probe_res_t               res
);

  logic [ohs_pkg::IDX_W-1:0] idx_x4;

  // idx*5 + 1 + perturb, kept to the index width (mask by truncation)
  assign idx_x4          = {idx[ohs_pkg::IDX_W-3:0], 2'b00};
  assign res.empty       = ~slot.valid;
  assign res.match       = slot.valid & (slot.key == key);
  assign res.nxt_idx     = idx + idx_x4 + ohs_pkg::IDX_W'(1)
                         + perturb[ohs_pkg::IDX_W-1:0];
  assign res.nxt_perturb = perturb >> ohs_pkg::PERT_SHIFT;

endmodule

/* design/open_addressing_hash_set.sv */
// Top level of the open-addressing hash set: sequencer, registers and ports.
//
// Open-addressing hash set of 64-bit keys with perturbed probing over 1024
// slots. Each request inserts a key or asks whether it is held; the key's
// 64-bit hash comes with it. Probing starts at the hash's low 10 bits and
// steps to index*5+1+perturb (perturb starting as the hash, shifted right by
// 5 after each step) until an empty slot or an equal key is found, or 1037
// slots have been probed. Each probe is one read of the slot memory and
// then one compare-and-step in the shared probe unit. A finished request
// holds the block while the previous result is still unread.
// in_tready is high only while no request is in progress. The result waits
// in an output register, so the next request is taken while it is still
// unread. After reset a clearing pass sweeps all 1024 slots, one per cycle;
// no request is taken during the pass, though register writes are.
// max_entries (byte address 0) is the load limit: an insert of a new key is
// refused with full_res once that many keys are held. Write it only while
// idle.
module open_addressing_hash_set (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key [63:0], key_hash [127:64]
  input  logic         in_tuser,   // cmd [0]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // hit [0], full_res [1], slot [11:2],
                                   // entries_held [22:12], zero [23]
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;

  localparam logic REG_MAX_ENTRIES = 1'b0;

  logic [2:0]                    state_r, state_nxt;
  logic [ohs_pkg::IDX_W-1:0]     clr_r, clr_nxt;
  logic [ohs_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [ohs_pkg::KEY_W-1:0]     perturb_r, perturb_nxt;
  logic [ohs_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic                          cmd_r, cmd_nxt;
  logic [ohs_pkg::PRB_W-1:0]     prb_r, prb_nxt;
  logic [ohs_pkg::CNT_W-1:0]     entry_cnt_r, entry_cnt_nxt;
  logic [ohs_pkg::CNT_W-1:0]     max_entries_r, max_entries_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          hit_r, hit_nxt;
  logic                          full_r, full_nxt;
  logic [ohs_pkg::IDX_W-1:0]     slot_r, slot_nxt;
  logic [ohs_pkg::CNT_W-1:0]     held_r, held_nxt;

  ohs_pkg::ram_req_t   ram_req;
  ohs_pkg::slot_word_t ram_rd;
  ohs_pkg::probe_res_t prb_res;

  logic in_acc;
  logic cfg_wr;
  logic load_ok;
  logic exhausted;
  logic done;
  logic at_limit;
  logic do_store;

  ohs_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  ohs_probe_unit u_probe (
    .slot    (ram_rd),
    .key     (key_r),
    .idx     (idx_r),
    .perturb (perturb_r),
    .res     (prb_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_ENTRIES)
                    ? {{(32 - ohs_pkg::CNT_W){1'b0}}, max_entries_r} : 32'd0;

  // result register frees when empty or being taken this cycle
  assign load_ok   = ~out_valid_r | out_tready;
  assign exhausted = (prb_r == ohs_pkg::PRB_W'(ohs_pkg::PROBE_LIMIT - 1));
  assign done      = prb_res.empty | prb_res.match | exhausted;
  assign at_limit  = (entry_cnt_r >= max_entries_r);
  assign do_store  = (state_r == ST_CHECK) & load_ok & (cmd_r == ohs_pkg::CMD_INSERT)
                   & prb_res.empty & ~at_limit;

  // memory requests: clearing sweep, probe reads, insert writes
  always_comb begin
    ram_req               = '0;
    ram_req.rd_en         = (state_r == ST_READ);
    ram_req.rd_addr       = idx_r;
    if (state_r == ST_CLEAR) begin
      ram_req.wr_en       = 1'b1;
      ram_req.wr_addr     = clr_r;
      ram_req.wr_data     = '0;
    end else begin
      ram_req.wr_en       = do_store;
      ram_req.wr_addr     = idx_r;
      ram_req.wr_data.valid = 1'b1;
      ram_req.wr_data.key = key_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    idx_nxt         = idx_r;
    perturb_nxt     = perturb_r;
    key_nxt         = key_r;
    cmd_nxt         = cmd_r;
    prb_nxt         = prb_r;
    entry_cnt_nxt   = entry_cnt_r;
    max_entries_nxt = max_entries_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    hit_nxt         = hit_r;
    full_nxt        = full_r;
    slot_nxt        = slot_r;
    held_nxt        = held_r;

    if (cfg_wr && (cfg_paddr[2] == REG_MAX_ENTRIES)) begin
      max_entries_nxt = cfg_pwdata[ohs_pkg::CNT_W-1:0];
    end

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ohs_pkg::IDX_W'(1);
        if (clr_r == ohs_pkg::IDX_W'(ohs_pkg::SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          // latch the request and start at the hash's low bits
          key_nxt     = in_tdata[63:0];
          perturb_nxt = in_tdata[127:64];
          idx_nxt     = in_tdata[64 +: ohs_pkg::IDX_W];
          cmd_nxt     = in_tuser;
          prb_nxt     = '0;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!done) begin
          // occupied by another key: advance to the next slot
          idx_nxt     = prb_res.nxt_idx;
          perturb_nxt = prb_res.nxt_perturb;
          prb_nxt     = prb_r + ohs_pkg::PRB_W'(1);
          state_nxt   = ST_READ;
        end else if (load_ok) begin
          // settle the request; otherwise hold until the result register frees
          slot_nxt      = idx_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (cmd_r == ohs_pkg::CMD_QUERY) begin
            hit_nxt  = prb_res.match;
            full_nxt = 1'b0;
            held_nxt = entry_cnt_r;
          end else if (prb_res.empty) begin
            hit_nxt  = ~at_limit;
            full_nxt = at_limit;
            held_nxt = at_limit ? entry_cnt_r : entry_cnt_r + ohs_pkg::CNT_W'(1);
            if (!at_limit) begin
              entry_cnt_nxt = entry_cnt_r + ohs_pkg::CNT_W'(1);
            end
          end else begin
            // key already held, or table exhausted
            hit_nxt  = 1'b0;
            full_nxt = ~prb_res.match;
            held_nxt = entry_cnt_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      entry_cnt_r   <= '0;
      max_entries_r <= ohs_pkg::MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      entry_cnt_r   <= entry_cnt_nxt;
      max_entries_r <= max_entries_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    perturb_r <= perturb_nxt;
    key_r     <= key_nxt;
    cmd_r     <= cmd_nxt;
    prb_r     <= prb_nxt;
    hit_r     <= hit_nxt;
    full_r    <= full_nxt;
    slot_r    <= slot_nxt;
    held_r    <= held_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, held_r, slot_r, full_r, hit_r};

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= ohs_pkg::CNT_W'(ohs_pkg::SLOTS))
    else $error("entry count beyond slot count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_cnt_r != $past(entry_cnt_r)) |->
      (entry_cnt_r == $past(entry_cnt_r) + ohs_pkg::CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_acc_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_READ))
    else $error("accepted request did not start a probe");

  a_out_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_CHECK))
    else $error("result raised outside the check step");

  a_store_empty: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |-> (prb_res.empty && (state_r == ST_CHECK)))
    else $error("store into an occupied slot");
`endif

endmodule
